// File: sv/uer_pkg.sv
// Shared types and constants for the ultrasonic echo ranging controller.
package uer_pkg;

    // Width of the reported tick count and distance fields.
    localparam int FIELD_W = 20;
    localparam logic [FIELD_W-1:0] FIELD_MAX = '1;

    // Width of the fixed-point scale factor and its fraction.
    localparam int SCALE_W = 16;
    localparam int SCALE_FRAC = 16;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 20;
    localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRE_LOW = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TRIGGER = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SETTLE = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOLDOFF = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCALE = 3'd6;

    // Configuration reset values.
    localparam logic RST_ENABLE = 1'b1;
    localparam logic [7:0] RST_PRE_LOW = 8'd4;
    localparam logic [7:0] RST_TRIGGER = 8'd22;
    localparam logic [FIELD_W-1:0] RST_TIMEOUT = 20'd60000;
    localparam logic [FIELD_W-1:0] RST_SETTLE = 20'd200000;
    localparam logic [FIELD_W-1:0] RST_HOLDOFF = 20'd120000;
    localparam logic [SCALE_W-1:0] RST_SCALE = 16'd5620;

    // Ranging phase codes.
    localparam int PHASE_W = 3;
    localparam logic [PHASE_W-1:0] PH_PRE_LOW = 3'd0;
    localparam logic [PHASE_W-1:0] PH_TRIGGER = 3'd1;
    localparam logic [PHASE_W-1:0] PH_WAIT = 3'd2;
    localparam logic [PHASE_W-1:0] PH_SETTLE = 3'd3;
    localparam logic [PHASE_W-1:0] PH_HOLDOFF = 3'd4;

    // Per-tick flags passed from the sequencer to the result stage.
    typedef struct packed {
        logic trigger;
        logic valid;
        logic status;
    } uer_flags_t;

    localparam int FLAGS_W = $bits(uer_flags_t);

endpackage

// File: sv/ultrasonic_echo_ranging.sv
// A tick beat accepted on the input passes through the queue, the multiply register
// and the output register before it is presented on the result channel.
// The block takes one tick beat per cycle while its queue is not full.
// A four-entry queue and a two-register result pipeline absorb output stalls.
// Reset (aresetn low at a rising edge) loads default registers and enters pre-low.
// Reset needs no clearing pass; the first tick beat may follow right after it.
module ultrasonic_echo_ranging #(
    parameter int COUNT_WIDTH = 21,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration write channel.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [uer_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [uer_pkg::CFG_DATA_W-1:0]      cfg_data,
    // Tick input channel.
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_echo_level,
    // Result channel.
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_trigger_level,
    output logic                                m_result_valid,
    output logic                                m_status,
    output logic [uer_pkg::FIELD_W-1:0]         m_high_ticks,
    output logic [uer_pkg::FIELD_W-1:0]         m_distance_mm
);

    localparam int Q_DATA_W = uer_pkg::FLAGS_W + COUNT_WIDTH;
    localparam int Q_LVL_W  = $clog2(QUEUE_DEPTH + 1);

    // Configuration registers. A write is taken only while no tick is being
    // accepted or waiting anywhere in the pipeline, so every tick sees the same
    // register values in the sequencer and in the result stage.
    logic                          enable_reg;
    logic [7:0]                    pre_low_reg;
    logic [7:0]                    trigger_reg;
    logic [uer_pkg::FIELD_W-1:0]   timeout_reg;
    logic [uer_pkg::FIELD_W-1:0]   settle_reg;
    logic [uer_pkg::FIELD_W-1:0]   holdoff_reg;
    logic [uer_pkg::SCALE_W-1:0]   scale_reg;

    logic                          cfg_we;

    assign cfg_we    = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg  <= uer_pkg::RST_ENABLE;
            pre_low_reg <= uer_pkg::RST_PRE_LOW;
            trigger_reg <= uer_pkg::RST_TRIGGER;
            timeout_reg <= uer_pkg::RST_TIMEOUT;
            settle_reg  <= uer_pkg::RST_SETTLE;
            holdoff_reg <= uer_pkg::RST_HOLDOFF;
            scale_reg   <= uer_pkg::RST_SCALE;
        end else if (cfg_we) begin
            case (cfg_index)
                uer_pkg::CFG_ENABLE:  enable_reg  <= cfg_data[0];
                uer_pkg::CFG_PRE_LOW: pre_low_reg <= cfg_data[7:0];
                uer_pkg::CFG_TRIGGER: trigger_reg <= cfg_data[7:0];
                uer_pkg::CFG_TIMEOUT: timeout_reg <= cfg_data[uer_pkg::FIELD_W-1:0];
                uer_pkg::CFG_SETTLE:  settle_reg  <= cfg_data[uer_pkg::FIELD_W-1:0];
                uer_pkg::CFG_HOLDOFF: holdoff_reg <= cfg_data[uer_pkg::FIELD_W-1:0];
                uer_pkg::CFG_SCALE:   scale_reg   <= cfg_data[uer_pkg::SCALE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The sequencer advances its phase state once per accepted tick and
    // pushes a compact record (flags plus captured echo count) into the queue.
    logic                        push;
    uer_pkg::uer_flags_t         push_flags;
    logic [COUNT_WIDTH-1:0]      push_count;
    logic                        q_full, q_not_empty, q_pop;
    logic [Q_DATA_W-1:0]         q_rd_data;
    logic [Q_LVL_W-1:0]          q_level;
    uer_pkg::uer_flags_t         q_flags;
    logic [COUNT_WIDTH-1:0]      q_count;
    logic                        back_busy;

    uer_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_echo_level  (s_echo_level),
        .queue_full    (q_full),
        .enable        (enable_reg),
        .pre_low_ticks (pre_low_reg),
        .trigger_ticks (trigger_reg),
        .timeout_ticks (timeout_reg),
        .settle_ticks  (settle_reg),
        .holdoff_ticks (holdoff_reg),
        .push          (push),
        .push_flags    (push_flags),
        .push_count    (push_count)
    );

    uer_queue #(
        .DATA_W (Q_DATA_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (push),
        .wr_data   ({push_flags, push_count}),
        .rd_en     (q_pop),
        .rd_data   (q_rd_data),
        .not_empty (q_not_empty),
        .full      (q_full),
        .level     (q_level)
    );

    assign q_flags = q_rd_data[Q_DATA_W-1 -: uer_pkg::FLAGS_W];
    assign q_count = q_rd_data[COUNT_WIDTH-1:0];

    // The result stage multiplies the captured count by the scale factor,
    // then saturates both reported fields into the output register.
    uer_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_not_empty     (q_not_empty),
        .q_flags         (q_flags),
        .q_count         (q_count),
        .q_pop           (q_pop),
        .distance_scale  (scale_reg),
        .busy            (back_busy),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_trigger_level (m_trigger_level),
        .m_result_valid  (m_result_valid),
        .m_status        (m_status),
        .m_high_ticks    (m_high_ticks),
        .m_distance_mm   (m_distance_mm)
    );

    // A register write waits until no tick is entering, queued or in the result
    // stage; a tick offered in the same cycle goes first.
    assign cfg_ready = !(push || q_not_empty || back_busy);

    // A timeout outcome never carries a measurement.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status) |-> (m_high_ticks == '0 && m_distance_mm == '0))
        else $error("timeout beat carries nonzero measurement");

    // The trigger pulse and an outcome report never share a tick.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_trigger_level) |-> !m_result_valid)
        else $error("trigger and result reported on the same tick");

    // The queue never holds more than its depth, and input stalls only when full.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_level <= Q_LVL_W'(QUEUE_DEPTH)) && (s_ready == (q_level != Q_LVL_W'(QUEUE_DEPTH))))
        else $error("queue level out of range or input stall mismatch");

endmodule

// File: sv/uer_front.sv
// Phase sequencer: takes one echo sample per beat and decides trigger and outcome.
module uer_front #(
    parameter int COUNT_WIDTH = 21
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_echo_level,
    input  logic                               queue_full,
    input  logic                               enable,
    input  logic [7:0]                         pre_low_ticks,
    input  logic [7:0]                         trigger_ticks,
    input  logic [uer_pkg::FIELD_W-1:0]        timeout_ticks,
    input  logic [uer_pkg::FIELD_W-1:0]        settle_ticks,
    input  logic [uer_pkg::FIELD_W-1:0]        holdoff_ticks,
    output logic                               push,
    output uer_pkg::uer_flags_t                push_flags,
    output logic [COUNT_WIDTH-1:0]             push_count
);

    localparam int CMP_W = (COUNT_WIDTH > uer_pkg::FIELD_W) ? COUNT_WIDTH : uer_pkg::FIELD_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    logic [uer_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0]      phase_cnt_reg, phase_cnt_next;
    logic [COUNT_WIDTH-1:0]      echo_cnt_reg, echo_cnt_next;
    logic                        echo_prev_reg;
    logic                        rise_reg, rise_next;

    logic [uer_pkg::PHASE_W-1:0] cur_phase;
    logic [uer_pkg::PHASE_W-1:0] target, skip1, skip2, skip3;
    logic [COUNT_WIDTH-1:0]      pc_inc;
    logic [uer_pkg::FIELD_W-1:0] cur_len;
    logic                        done;
    logic                        enter;
    logic                        fall;

    assign s_ready = !queue_full;
    assign push    = s_valid && s_ready;

    assign cur_phase = (phase_reg > uer_pkg::PH_HOLDOFF) ? uer_pkg::PH_PRE_LOW : phase_reg;
    assign pc_inc    = (phase_cnt_reg == CNT_MAX) ? CNT_MAX : phase_cnt_reg + 1'b1;
    assign fall      = rise_reg && !s_echo_level && echo_prev_reg;

    always_comb begin
        case (cur_phase)
            uer_pkg::PH_PRE_LOW: cur_len = uer_pkg::FIELD_W'(pre_low_ticks);
            uer_pkg::PH_TRIGGER: begin
                cur_len = (trigger_ticks == 8'd0) ? uer_pkg::FIELD_W'(1)
                                                  : uer_pkg::FIELD_W'(trigger_ticks);
            end
            uer_pkg::PH_WAIT: begin
                cur_len = (timeout_ticks == '0) ? uer_pkg::FIELD_W'(1) : timeout_ticks;
            end
            uer_pkg::PH_SETTLE: cur_len = settle_ticks;
            default: cur_len = holdoff_ticks;
        endcase
    end

    assign done = (CMP_W'(pc_inc) >= CMP_W'(cur_len)) || (pc_inc == CNT_MAX);

    // Zero-length settle, holdoff and pre-low phases are skipped in the order they would be entered.
    assign skip1 = (target == uer_pkg::PH_SETTLE && settle_ticks == '0)
                   ? uer_pkg::PH_HOLDOFF : target;
    assign skip2 = (skip1 == uer_pkg::PH_HOLDOFF && holdoff_ticks == '0)
                   ? uer_pkg::PH_PRE_LOW : skip1;
    assign skip3 = (skip2 == uer_pkg::PH_PRE_LOW && pre_low_ticks == 8'd0)
                   ? uer_pkg::PH_TRIGGER : skip2;

    always_comb begin
        phase_next     = cur_phase;
        phase_cnt_next = phase_cnt_reg;
        rise_next      = rise_reg;
        echo_cnt_next  = echo_cnt_reg;
        push_flags     = '0;
        push_count     = '0;
        enter          = 1'b0;
        target         = uer_pkg::PH_PRE_LOW;
        if (!enable) begin
            phase_next     = uer_pkg::PH_PRE_LOW;
            phase_cnt_next = '0;
            rise_next      = 1'b0;
            echo_cnt_next  = '0;
        end else begin
            case (cur_phase)
                uer_pkg::PH_PRE_LOW: begin
                    target = uer_pkg::PH_TRIGGER;
                    enter  = done;
                    phase_cnt_next = pc_inc;
                end
                uer_pkg::PH_TRIGGER: begin
                    push_flags.trigger = 1'b1;
                    target = uer_pkg::PH_WAIT;
                    enter  = done;
                    phase_cnt_next = pc_inc;
                end
                uer_pkg::PH_WAIT: begin
                    if (fall) begin
                        push_flags.valid = 1'b1;
                        push_count       = echo_cnt_reg;
                        target = uer_pkg::PH_SETTLE;
                        enter  = 1'b1;
                    end else begin
                        if (!rise_reg) begin
                            if (s_echo_level && !echo_prev_reg) begin
                                rise_next     = 1'b1;
                                echo_cnt_next = COUNT_WIDTH'(1);
                            end
                        end else if (s_echo_level) begin
                            echo_cnt_next = (echo_cnt_reg == CNT_MAX) ? CNT_MAX
                                                                      : echo_cnt_reg + 1'b1;
                        end
                        phase_cnt_next = pc_inc;
                        if (done) begin
                            push_flags.valid  = 1'b1;
                            push_flags.status = 1'b1;
                            target = uer_pkg::PH_HOLDOFF;
                            enter  = 1'b1;
                        end
                    end
                end
                uer_pkg::PH_SETTLE: begin
                    target = uer_pkg::PH_HOLDOFF;
                    enter  = done;
                    phase_cnt_next = pc_inc;
                end
                default: begin
                    target = uer_pkg::PH_PRE_LOW;
                    enter  = done;
                    phase_cnt_next = pc_inc;
                end
            endcase
            if (enter) begin
                phase_next     = skip3;
                phase_cnt_next = '0;
                if (skip3 == uer_pkg::PH_WAIT) begin
                    rise_next     = 1'b0;
                    echo_cnt_next = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= uer_pkg::PH_PRE_LOW;
            phase_cnt_reg <= '0;
            echo_cnt_reg  <= '0;
            echo_prev_reg <= 1'b0;
            rise_reg      <= 1'b0;
        end else if (push) begin
            phase_reg     <= phase_next;
            phase_cnt_reg <= phase_cnt_next;
            echo_cnt_reg  <= echo_cnt_next;
            echo_prev_reg <= s_echo_level;
            rise_reg      <= rise_next;
        end
    end

endmodule

// File: sv/uer_queue.sv
// Small first-in first-out queue between the sequencer and the result stage.
module uer_queue #(
    parameter int DATA_W = 24,
    parameter int DEPTH  = 4
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         wr_en,
    input  logic [DATA_W-1:0]            wr_data,
    input  logic                         rd_en,
    output logic [DATA_W-1:0]            rd_data,
    output logic                         not_empty,
    output logic                         full,
    output logic [$clog2(DEPTH+1)-1:0]   level
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W = $clog2(DEPTH+1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0]  level_reg, level_next;
    logic              do_wr, do_rd;

    assign full      = (level_reg == LVL_W'(DEPTH));
    assign not_empty = (level_reg != '0);
    assign level     = level_reg;
    assign rd_data   = mem_reg[rd_ptr_reg];

    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && not_empty;

    assign wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;

    always_comb begin
        level_next = level_reg;
        if (do_wr && !do_rd) begin
            level_next = level_reg + 1'b1;
        end else if (do_rd && !do_wr) begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (do_rd) begin
                rd_ptr_reg <= rd_ptr_next;
            end
            level_reg <= level_next;
        end
    end

endmodule

// File: sv/uer_back.sv
// Result stage: scales the echo count to a distance, saturates and holds the output beat.
module uer_back #(
    parameter int COUNT_WIDTH = 21
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               q_not_empty,
    input  uer_pkg::uer_flags_t                q_flags,
    input  logic [COUNT_WIDTH-1:0]             q_count,
    output logic                               q_pop,
    input  logic [uer_pkg::SCALE_W-1:0]        distance_scale,
    output logic                               busy,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_trigger_level,
    output logic                               m_result_valid,
    output logic                               m_status,
    output logic [uer_pkg::FIELD_W-1:0]        m_high_ticks,
    output logic [uer_pkg::FIELD_W-1:0]        m_distance_mm
);

    localparam int PROD_W = COUNT_WIDTH + uer_pkg::SCALE_W;
    localparam logic [PROD_W-1:0] SAT_LIMIT = PROD_W'(uer_pkg::FIELD_MAX);

    // Multiply stage.
    logic                      s1_valid_reg;
    uer_pkg::uer_flags_t       s1_flags_reg;
    logic [COUNT_WIDTH-1:0]    s1_count_reg;
    logic [PROD_W-1:0]         s1_prod_reg;

    // Output stage.
    logic                      out_valid_reg;
    uer_pkg::uer_flags_t       out_flags_reg;
    logic [uer_pkg::FIELD_W-1:0] out_ticks_reg, out_ticks_next;
    logic [uer_pkg::FIELD_W-1:0] out_dist_reg, out_dist_next;

    logic              out_free, s1_free;
    logic [PROD_W-1:0] count_ext, dist_full;

    assign out_free = !out_valid_reg || m_ready;
    assign s1_free  = !s1_valid_reg || out_free;
    assign q_pop    = q_not_empty && s1_free;
    assign busy     = s1_valid_reg || out_valid_reg;

    assign count_ext = PROD_W'(s1_count_reg);
    assign dist_full = s1_prod_reg >> uer_pkg::SCALE_FRAC;

    assign out_ticks_next = (count_ext > SAT_LIMIT) ? uer_pkg::FIELD_MAX
                                                    : count_ext[uer_pkg::FIELD_W-1:0];
    assign out_dist_next  = (dist_full > SAT_LIMIT) ? uer_pkg::FIELD_MAX
                                                    : dist_full[uer_pkg::FIELD_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s1_free) begin
                s1_valid_reg <= q_not_empty;
            end
            if (out_free) begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            s1_flags_reg <= q_flags;
            s1_count_reg <= q_count;
            s1_prod_reg  <= PROD_W'(q_count) * PROD_W'(distance_scale);
        end
        if (out_free && s1_valid_reg) begin
            out_flags_reg <= s1_flags_reg;
            out_ticks_reg <= out_ticks_next;
            out_dist_reg  <= out_dist_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_trigger_level = out_flags_reg.trigger;
    assign m_result_valid  = out_flags_reg.valid;
    assign m_status        = out_flags_reg.status;
    assign m_high_ticks    = out_ticks_reg;
    assign m_distance_mm   = out_dist_reg;

endmodule

// File: sim/ultrasonic_echo_ranging_test.sv
// Self-checking testbench for the ultrasonic echo ranging controller.
`timescale 1ns / 100ps

module ultrasonic_echo_ranging_test;

    // Counter width of the ranging sequencer and its saturation value.
    localparam int CNT_W = 21;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Depth of the path from an accepted tick beat to the result channel.
    localparam int RESULT_LATENCY = 3;
    localparam int NUM_REGS = uer_pkg::CFG_SCALE + 1;

    // Index past the end of the register list; writes to it must be ignored.
    localparam logic [uer_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 3'd7;

    // Values of the status field.
    localparam logic ST_ECHO = 1'b0;
    localparam logic ST_NO_ECHO = 1'b1;

    // Random segments; a few of them carry the extreme register settings.
    localparam int NUM_SEGS = 9;
    localparam int SEG_SCALE_ZERO = 1;
    localparam int SEG_LONG_PHASES = 4;
    localparam int SEG_DISABLED = 5;
    localparam int SEG_LONG_WAITS = 7;

    // Hard stop, far beyond the slowest correct run.
    localparam int WATCHDOG_NS = 2_000_000;

    // What the block reports for one tick.
    typedef struct packed {
        logic                         trigger;
        logic                         result_valid;
        logic                         status;
        logic [uer_pkg::FIELD_W-1:0]  high_ticks;
        logic [uer_pkg::FIELD_W-1:0]  distance_mm;
    } tick_report_t;

    localparam tick_report_t RPT_QUIET = '0;
    localparam tick_report_t RPT_TRIGGER = '{1'b1, 1'b0, ST_ECHO, 20'd0, 20'd0};
    localparam tick_report_t RPT_NO_ECHO = '{1'b0, 1'b1, ST_NO_ECHO, 20'd0, 20'd0};
    // Three high ticks at full scale: (3 * 65535) >> 16 gives 2 mm.
    localparam tick_report_t RPT_THREE_TICKS = '{1'b0, 1'b1, ST_ECHO, 20'd3, 20'd2};

    typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t                        kind;
        logic [uer_pkg::CFG_INDEX_W-1:0]  index;
        logic [uer_pkg::CFG_DATA_W-1:0]   data;
        logic                             echo;
        logic                             typed;
        tick_report_t                     want;
    } opening_row_t;

    // Opening sequence. Rows with typed set carry a report that can be read off by
    // hand; the rest are checked against the predictor. The short register values
    // with junk above bit 7 also check that the block keeps only the low byte.
    localparam int NUM_ROWS = 25;
    localparam opening_row_t OPENING_ROWS [NUM_ROWS] = '{
        // Right after reset the block counts pre-low with the trigger low.
        '{ROW_TICK, uer_pkg::CFG_ENABLE,  20'h00000, 1'b0, 1'b1, RPT_QUIET},
        // Zero pre-low is skipped; a zero pulse length acts as one tick.
        '{ROW_CFG,  uer_pkg::CFG_PRE_LOW, 20'h00300, 1'b0, 1'b0, RPT_QUIET},
        '{ROW_CFG,  uer_pkg::CFG_TRIGGER, 20'h00100, 1'b0, 1'b0, RPT_QUIET},
        '{ROW_CFG,  uer_pkg::CFG_TIMEOUT, 20'd2,     1'b0, 1'b0, RPT_QUIET},
        '{ROW_CFG,  uer_pkg::CFG_SETTLE,  20'd0,     1'b0, 1'b0, RPT_QUIET},
        '{ROW_CFG,  uer_pkg::CFG_HOLDOFF, 20'd0,     1'b0, 1'b0, RPT_QUIET},
        '{ROW_CFG,  uer_pkg::CFG_SCALE,   20'h0FFFF, 1'b0, 1'b0, RPT_QUIET},
        '{ROW_TICK, uer_pkg::CFG_ENABLE,  20'h00000, 1'b0, 1'b0, RPT_QUIET},
        // Echo already high while the pulse is out: no true rising edge follows.
        '{ROW_TICK, uer_pkg::CFG_ENABLE,  20'h00000, 1'b1, 1'b1, RPT_TRIGGER},
        '{ROW_TICK, uer_pkg::CFG_ENABLE,  20'h00000, 1'b1, 1'b0, RPT_QUIET},
        '{ROW_TICK, uer_pkg::CFG_ENABLE,  20'h00000, 1'b1, 1'b1, RPT_NO_ECHO},
        '{ROW_TICK, uer_pkg::CFG_ENABLE,  20'h00000, 1'b0, 1'b1, RPT_TRIGGER},
        // A zero timeout acts as one tick, even with a rising edge on that tick.
        '{ROW_CFG,  uer_pkg::CFG_TIMEOUT, 20'd0,     1'b0, 1'b0, RPT_QUIET},
        '{ROW_TICK, uer_pkg::CFG_ENABLE,  20'h00000, 1'b1, 1'b1, RPT_NO_ECHO},
        // Longest timeout, then a clean three-tick echo.
        '{ROW_CFG,  uer_pkg::CFG_TIMEOUT, 20'hFFFFF, 1'b0, 1'b0, RPT_QUIET},
        '{ROW_TICK, uer_pkg::CFG_ENABLE,  20'h00000, 1'b0, 1'b1, RPT_TRIGGER},
        '{ROW_TICK, uer_pkg::CFG_ENABLE,  20'h00000, 1'b0, 1'b0, RPT_QUIET},
        '{ROW_TICK, uer_pkg::CFG_ENABLE,  20'h00000, 1'b1, 1'b0, RPT_QUIET},
        '{ROW_TICK, uer_pkg::CFG_ENABLE,  20'h00000, 1'b1, 1'b0, RPT_QUIET},
        '{ROW_TICK, uer_pkg::CFG_ENABLE,  20'h00000, 1'b1, 1'b0, RPT_QUIET},
        '{ROW_TICK, uer_pkg::CFG_ENABLE,  20'h00000, 1'b0, 1'b1, RPT_THREE_TICKS},
        // Disabled: idle with the trigger low, whatever the echo does.
        '{ROW_CFG,  uer_pkg::CFG_ENABLE,  20'h00000, 1'b0, 1'b0, RPT_QUIET},
        '{ROW_TICK, uer_pkg::CFG_ENABLE,  20'h00000, 1'b1, 1'b1, RPT_QUIET},
        // A write past the register list must change nothing.
        '{ROW_CFG,  CFG_UNUSED,           20'hFFFFF, 1'b0, 1'b0, RPT_QUIET},
        '{ROW_CFG,  uer_pkg::CFG_ENABLE,  20'h00001, 1'b0, 1'b0, RPT_QUIET}
    };

    // Every input starts at a known value.
    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [uer_pkg::CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [uer_pkg::CFG_DATA_W-1:0]   cfg_data = '0;
    logic                             s_valid = 1'b0;
    logic                             s_ready;
    logic                             s_echo_level = 1'b0;
    logic                             m_valid;
    logic                             m_ready = 1'b0;
    logic                             m_trigger_level;
    logic                             m_result_valid;
    logic                             m_status;
    logic [uer_pkg::FIELD_W-1:0]      m_high_ticks;
    logic [uer_pkg::FIELD_W-1:0]      m_distance_mm;

    // Percent of cycles in which the sender holds back a beat, and in which the
    // receiver refuses one.
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int mismatches = 0;

    // Reports still owed by the block, oldest first.
    tick_report_t awaited_reports [$];

    // Register copy of the predictor, loaded with the reset values.
    logic                             cfg_en = uer_pkg::RST_ENABLE;
    logic [7:0]                       cfg_pre_low = uer_pkg::RST_PRE_LOW;
    logic [7:0]                       cfg_trig = uer_pkg::RST_TRIGGER;
    logic [uer_pkg::FIELD_W-1:0]      cfg_timeout = uer_pkg::RST_TIMEOUT;
    logic [uer_pkg::FIELD_W-1:0]      cfg_settle = uer_pkg::RST_SETTLE;
    logic [uer_pkg::FIELD_W-1:0]      cfg_holdoff = uer_pkg::RST_HOLDOFF;
    logic [uer_pkg::SCALE_W-1:0]      cfg_scale = uer_pkg::RST_SCALE;

    // Sequencer state of the predictor.
    logic [uer_pkg::PHASE_W-1:0]      ph = uer_pkg::PH_PRE_LOW;
    logic [CNT_W-1:0]                 ph_count = '0;
    logic                             echo_prev = 1'b0;
    logic                             rise_seen = 1'b0;
    logic [CNT_W-1:0]                 echo_count = '0;

    ultrasonic_echo_ranging uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_echo_level    (s_echo_level),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_trigger_level (m_trigger_level),
        .m_result_valid  (m_result_valid),
        .m_status        (m_status),
        .m_high_ticks    (m_high_ticks),
        .m_distance_mm   (m_distance_mm)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Enter a phase. Zero-length pre-low, settle and holdoff fall through to the
    // phase after them; entering the wait clears the echo timing.
    function automatic void enter_phase(logic [uer_pkg::PHASE_W-1:0] next_ph);
        logic [uer_pkg::PHASE_W-1:0] p;
        p = next_ph;
        for (int i = 0; i < 3; i++) begin
            if (p == uer_pkg::PH_PRE_LOW && cfg_pre_low == '0) begin
                p = uer_pkg::PH_TRIGGER;
            end else if (p == uer_pkg::PH_SETTLE && cfg_settle == '0) begin
                p = uer_pkg::PH_HOLDOFF;
            end else if (p == uer_pkg::PH_HOLDOFF && cfg_holdoff == '0) begin
                p = uer_pkg::PH_PRE_LOW;
            end
        end
        ph = p;
        ph_count = '0;
        if (p == uer_pkg::PH_WAIT) begin
            rise_seen = 1'b0;
            echo_count = '0;
        end
    endfunction

    // Count one tick of a timed phase; true once the phase has run its length or
    // the counter has saturated.
    function automatic bit phase_over(logic [CNT_W-1:0] len);
        if (ph_count != CNT_MAX) begin
            ph_count = ph_count + 1'b1;
        end
        return (ph_count >= len) || (ph_count == CNT_MAX);
    endfunction

    // Predictor: advance the sequencer copy by one tick and return its report.
    function automatic tick_report_t ranging_report(logic echo);
        tick_report_t r;
        logic [CNT_W+uer_pkg::SCALE_W-1:0] prod;
        r = RPT_QUIET;
        if (ph > uer_pkg::PH_HOLDOFF) begin
            ph = uer_pkg::PH_PRE_LOW;
        end
        if (!cfg_en) begin
            ph = uer_pkg::PH_PRE_LOW;
            ph_count = '0;
            rise_seen = 1'b0;
            echo_count = '0;
        end else begin
            case (ph)
                uer_pkg::PH_PRE_LOW: begin
                    if (phase_over({13'd0, cfg_pre_low})) enter_phase(uer_pkg::PH_TRIGGER);
                end
                uer_pkg::PH_TRIGGER: begin
                    r.trigger = 1'b1;
                    if (phase_over((cfg_trig == '0) ? 21'd1 : {13'd0, cfg_trig})) begin
                        enter_phase(uer_pkg::PH_WAIT);
                    end
                end
                uer_pkg::PH_WAIT: begin
                    if (rise_seen && !echo && echo_prev) begin
                        // Falling edge: report the pulse, even on the timeout tick.
                        prod = echo_count * cfg_scale;
                        prod = prod >> uer_pkg::SCALE_FRAC;
                        r.result_valid = 1'b1;
                        r.status = ST_ECHO;
                        r.high_ticks = (echo_count > uer_pkg::FIELD_MAX)
                                       ? uer_pkg::FIELD_MAX
                                       : echo_count[uer_pkg::FIELD_W-1:0];
                        r.distance_mm = (prod > uer_pkg::FIELD_MAX)
                                        ? uer_pkg::FIELD_MAX
                                        : prod[uer_pkg::FIELD_W-1:0];
                        enter_phase(uer_pkg::PH_SETTLE);
                    end else begin
                        if (!rise_seen) begin
                            if (echo && !echo_prev) begin
                                rise_seen = 1'b1;
                                echo_count = 21'd1;
                            end
                        end else if (echo && echo_count != CNT_MAX) begin
                            echo_count = echo_count + 1'b1;
                        end
                        if (phase_over((cfg_timeout == '0) ? 21'd1 : {1'b0, cfg_timeout}))
                        begin
                            r.result_valid = 1'b1;
                            r.status = ST_NO_ECHO;
                            enter_phase(uer_pkg::PH_HOLDOFF);
                        end
                    end
                end
                uer_pkg::PH_SETTLE: begin
                    if (phase_over({1'b0, cfg_settle})) enter_phase(uer_pkg::PH_HOLDOFF);
                end
                default: begin
                    if (phase_over({1'b0, cfg_holdoff})) enter_phase(uer_pkg::PH_PRE_LOW);
                end
            endcase
        end
        echo_prev = echo;
        return r;
    endfunction

    // Offer one tick beat, starting at a falling edge, and return at the falling edge
    // after it was taken. The predicted report, or the typed one, goes on the queue.
    task automatic send_tick(logic echo, logic typed, tick_report_t want);
        tick_report_t r;
        cfg_valid <= 1'b0;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_echo_level <= echo;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        r = ranging_report(echo);
        awaited_reports.push_back(typed ? want : r);
        @(negedge aclk);
    endtask

    // Write one register and update the predictor's copy of it. The valid is left
    // high so that writes can follow back to back; the next task lowers it.
    task automatic cfg_write(logic [uer_pkg::CFG_INDEX_W-1:0] idx,
                             logic [uer_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            uer_pkg::CFG_ENABLE:  cfg_en = data[0];
            uer_pkg::CFG_PRE_LOW: cfg_pre_low = data[7:0];
            uer_pkg::CFG_TRIGGER: cfg_trig = data[7:0];
            uer_pkg::CFG_TIMEOUT: cfg_timeout = data;
            uer_pkg::CFG_SETTLE:  cfg_settle = data;
            uer_pkg::CFG_HOLDOFF: cfg_holdoff = data;
            uer_pkg::CFG_SCALE:   cfg_scale = data[uer_pkg::SCALE_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
    endtask

    // Stop offering beats and let every owed report arrive, plus the pipeline depth.
    task automatic wait_quiet();
        s_valid <= 1'b0;
        cfg_valid <= 1'b0;
        while (awaited_reports.size() != 0) @(negedge aclk);
        repeat (RESULT_LATENCY + 2) @(negedge aclk);
    endtask

    // The receiver refuses beats at random.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Compare each report beat with the oldest one owed.
    always @(posedge aclk) begin
        tick_report_t exp_rpt;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_reports.size() == 0) begin
                $error("report beat with none owed");
                mismatches++;
            end else begin
                exp_rpt = awaited_reports.pop_front();
                if (m_trigger_level !== exp_rpt.trigger) begin
                    $error("trigger_level: expected %0d, got %0d",
                           exp_rpt.trigger, m_trigger_level);
                    mismatches++;
                end
                if (m_result_valid !== exp_rpt.result_valid) begin
                    $error("result_valid: expected %0d, got %0d",
                           exp_rpt.result_valid, m_result_valid);
                    mismatches++;
                end
                if (m_status !== exp_rpt.status) begin
                    $error("status: expected %0d, got %0d", exp_rpt.status, m_status);
                    mismatches++;
                end
                if (m_high_ticks !== exp_rpt.high_ticks) begin
                    $error("high_ticks: expected %0d, got %0d",
                           exp_rpt.high_ticks, m_high_ticks);
                    mismatches++;
                end
                if (m_distance_mm !== exp_rpt.distance_mm) begin
                    $error("distance_mm: expected %0d, got %0d",
                           exp_rpt.distance_mm, m_distance_mm);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        logic [uer_pkg::CFG_DATA_W-1:0] seg_regs [NUM_REGS];
        int seg_len;
        int span;
        int plan_delay;
        int plan_width;
        bit plan_noise;
        logic echo;

        plan_delay = 0;
        plan_width = 0;
        plan_noise = 1'b0;

        // Synchronous reset, released at a falling edge.
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // The opening rows run with a lazy receiver and an eager sender.
        tx_idle_pct = 10;
        rx_idle_pct = 73;
        foreach (OPENING_ROWS[i]) begin
            if (OPENING_ROWS[i].kind == ROW_CFG) begin
                wait_quiet();
                cfg_write(OPENING_ROWS[i].index, OPENING_ROWS[i].data);
            end else begin
                send_tick(OPENING_ROWS[i].echo, OPENING_ROWS[i].typed, OPENING_ROWS[i].want);
            end
        end

        // Random segments. Each one programs every register while the block is
        // quiet, then streams ticks. The first third keeps the receiver slow, the
        // second keeps the sender slow and the last runs flat out.
        for (int seg = 0; seg < NUM_SEGS; seg++) begin
            case (seg / 3)
                0: begin
                    tx_idle_pct = 10;
                    rx_idle_pct = 73;
                end
                1: begin
                    tx_idle_pct = 73;
                    rx_idle_pct = 10;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase

            // Mostly short phases so that many ranging cycles complete. Junk above
            // the narrow registers must be dropped by the block.
            seg_regs[uer_pkg::CFG_ENABLE] = 20'(32'd1 | ($urandom() & 32'hFFFFE));
            seg_regs[uer_pkg::CFG_PRE_LOW] = 20'(32'($urandom_range(0, 6))
                                                 | ($urandom() & 32'hFFF00));
            seg_regs[uer_pkg::CFG_TRIGGER] = 20'(32'($urandom_range(0, 6))
                                                 | ($urandom() & 32'hFFF00));
            seg_regs[uer_pkg::CFG_TIMEOUT] = 20'($urandom_range(0, 40));
            seg_regs[uer_pkg::CFG_SETTLE] = 20'($urandom_range(0, 8));
            seg_regs[uer_pkg::CFG_HOLDOFF] = 20'($urandom_range(0, 8));
            seg_regs[uer_pkg::CFG_SCALE] = ($urandom_range(0, 3) == 0)
                                           ? 20'h0FFFF : 20'($urandom() & 32'hFFFF);
            seg_len = 50;
            case (seg)
                SEG_SCALE_ZERO: begin
                    seg_regs[uer_pkg::CFG_SCALE] = 20'hF0000;
                end
                SEG_LONG_PHASES: begin
                    // Longest pre-low and pulse; one full cycle needs over 510 ticks.
                    seg_regs[uer_pkg::CFG_PRE_LOW] = 20'h000FF;
                    seg_regs[uer_pkg::CFG_TRIGGER] = 20'h7FFFF;
                    seg_regs[uer_pkg::CFG_TIMEOUT] = 20'($urandom_range(1, 20));
                    seg_len = 560;
                end
                SEG_DISABLED: begin
                    seg_regs[uer_pkg::CFG_ENABLE] = 20'hFFFFE;
                    seg_len = 30;
                end
                SEG_LONG_WAITS: begin
                    // Longest timeout, settle and holdoff; the next segment cuts
                    // them short again.
                    seg_regs[uer_pkg::CFG_TIMEOUT] = 20'hFFFFF;
                    seg_regs[uer_pkg::CFG_SETTLE] = 20'hFFFFF;
                    seg_regs[uer_pkg::CFG_HOLDOFF] = 20'hFFFFF;
                    seg_regs[uer_pkg::CFG_SCALE] = 20'h0FFFF;
                    seg_len = 80;
                end
                default: ;
            endcase

            wait_quiet();
            for (int r = 0; r < NUM_REGS; r++) begin
                cfg_write(uer_pkg::CFG_INDEX_W'(r), seg_regs[r]);
            end

            for (int n = 0; n < seg_len; n++) begin
                if (cfg_en && ph == uer_pkg::PH_WAIT) begin
                    // On the first wait tick plan the echo: mostly one clean pulse
                    // that may or may not end before the timeout, sometimes noise.
                    if (ph_count == '0) begin
                        span = (cfg_timeout == '0) ? 1 : int'(cfg_timeout);
                        if (span > 80) span = 80;
                        plan_noise = ($urandom_range(0, 6) == 0);
                        plan_delay = $urandom_range(0, span / 3);
                        plan_width = $urandom_range(1, span * 2 / 3 + 1);
                    end
                    if (plan_noise) begin
                        echo = 1'($urandom_range(0, 1));
                    end else begin
                        echo = (ph_count >= plan_delay) && (ph_count < plan_delay + plan_width);
                    end
                end else begin
                    // Outside the wait the line is mostly low with stray spikes.
                    echo = ($urandom_range(0, 19) == 0);
                end
                send_tick(echo, 1'b0, RPT_QUIET);
            end
        end

        wait_quiet();
        if (mismatches == 0) begin
            $display("PASS ultrasonic_echo_ranging");
        end else begin
            $display("FAIL ultrasonic_echo_ranging");
        end
        $finish;
    end

    // Watchdog in case a handshake never completes.
    initial begin
        #(WATCHDOG_NS);
        $display("FAIL ultrasonic_echo_ranging");
        $finish;
    end

endmodule

// File: sim.f
sv/uer_pkg.sv
sv/uer_front.sv
sv/uer_queue.sv
sv/uer_back.sv
sv/ultrasonic_echo_ranging.sv
sim/ultrasonic_echo_ranging_test.sv
